[hw/rtl/dxt_texture_block_decoder_macros.svh]
// Assertion helpers used by the dxt_back module.
`ifndef DXT_TEXTURE_BLOCK_DECODER_MACROS_SVH
`define DXT_TEXTURE_BLOCK_DECODER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DXT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DXT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/dxt_pkg.sv]
package dxt_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_DECODE_MODE  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;

    localparam int RECIP3 = 683;
    localparam int RECIP5 = 3277;
    localparam int RECIP7 = 2341;

    typedef struct packed {
        logic [3:0][2:0][7:0] pal;
        logic [7:0][7:0]      ramp;
        logic                 dxt5;
        logic                 trans3;
        logic [31:0]          cidx;
        logic [47:0]          aidx;
        logic [13:0]          bx;
        logic [13:0]          by;
        logic [15:0]          mask;
    } t_blk;

    typedef struct packed {
        logic [15:0] pixel_x;
        logic [15:0] pixel_y;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic        last_pixel;
    } t_pix;

    function automatic logic [7:0] div3(input logic [9:0] n);
        logic [19:0] prod;
        prod = {10'b0, n} * 20'(RECIP3);
        return prod[18:11];
    endfunction

    function automatic logic [7:0] div5(input logic [10:0] n);
        logic [21:0] prod;
        prod = {11'b0, n} * 22'(RECIP5);
        return prod[21:14];
    endfunction

    function automatic logic [7:0] div7(input logic [10:0] n);
        logic [21:0] prod;
        prod = {11'b0, n} * 22'(RECIP7);
        return prod[21:14];
    endfunction

endpackage

[hw/rtl/dxt_front.sv]
module dxt_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_decode_mode,
    input  logic [15:0]   i_image_width,
    input  logic [15:0]   i_image_height,
    input  logic          i_s_valid,
    output logic          o_s_ready,
    input  logic [63:0]   i_color_part,
    input  logic [63:0]   i_alpha_part,
    input  logic [13:0]   i_block_col,
    input  logic [13:0]   i_block_row,
    output logic          o_q_valid,
    input  logic          i_q_ready,
    output dxt_pkg::t_blk o_q_data
);

    typedef struct packed {
        logic [2:0][7:0]  e0;
        logic [2:0][7:0]  e1;
        logic [2:0][9:0]  s_a;
        logic [2:0][9:0]  s_b;
        logic [2:0][7:0]  half;
        logic             four;
        logic             dxt5;
        logic [7:0]       a0;
        logic [7:0]       a1;
        logic             a_gt;
        logic [5:0][10:0] asum;
        logic [31:0]      cidx;
        logic [47:0]      aidx;
        logic [13:0]      bx;
        logic [13:0]      by;
        logic [15:0]      mask;
    } t_sums;

    logic   r_valid;
    t_sums  r_sums;
    t_sums  n_sums;
    logic   w_advance;
    logic   w_load;
    logic [15:0] w_c0;
    logic [15:0] w_c1;
    logic [3:0]  w_col_ok;
    logic [3:0]  w_row_ok;
    logic [8:0]  w_sum9;

    assign w_advance = r_valid && ((r_sums.mask == 16'd0) || i_q_ready);
    assign o_s_ready = !r_valid || w_advance;
    assign w_load    = i_s_valid && o_s_ready;
    assign o_q_valid = r_valid && (r_sums.mask != 16'd0);

    assign w_c0 = i_color_part[15:0];
    assign w_c1 = i_color_part[31:16];

    always_comb begin
        n_sums = '0;
        w_sum9 = '0;
        n_sums.e0[dxt_pkg::CH_RED]   = {w_c0[15:11], 3'b0};
        n_sums.e0[dxt_pkg::CH_GREEN] = {w_c0[10:5], 2'b0};
        n_sums.e0[dxt_pkg::CH_BLUE]  = {w_c0[4:0], 3'b0};
        n_sums.e1[dxt_pkg::CH_RED]   = {w_c1[15:11], 3'b0};
        n_sums.e1[dxt_pkg::CH_GREEN] = {w_c1[10:5], 2'b0};
        n_sums.e1[dxt_pkg::CH_BLUE]  = {w_c1[4:0], 3'b0};
        for (int ch = 0; ch < 3; ch++) begin
            n_sums.s_a[ch] = {1'b0, n_sums.e0[ch], 1'b0} + {2'b0, n_sums.e1[ch]};
            n_sums.s_b[ch] = {2'b0, n_sums.e0[ch]} + {1'b0, n_sums.e1[ch], 1'b0};
            w_sum9 = {1'b0, n_sums.e0[ch]} + {1'b0, n_sums.e1[ch]};
            n_sums.half[ch] = w_sum9[8:1];
        end
        n_sums.dxt5 = i_decode_mode;
        n_sums.four = i_decode_mode || (w_c0 > w_c1);
        n_sums.a0   = i_alpha_part[7:0];
        n_sums.a1   = i_alpha_part[15:8];
        n_sums.a_gt = n_sums.a0 > n_sums.a1;
        for (int i = 2; i < 8; i++) begin
            if (n_sums.a_gt) begin
                n_sums.asum[i-2] = 11'(8 - i) * {3'b0, n_sums.a0}
                                 + 11'(i - 1) * {3'b0, n_sums.a1};
            end else if (i < 6) begin
                n_sums.asum[i-2] = 11'(6 - i) * {3'b0, n_sums.a0}
                                 + 11'(i - 1) * {3'b0, n_sums.a1};
            end else begin
                n_sums.asum[i-2] = '0;
            end
        end
        n_sums.cidx = i_color_part[63:32];
        n_sums.aidx = i_alpha_part[63:16];
        n_sums.bx   = i_block_col;
        n_sums.by   = i_block_row;
        for (int k = 0; k < 4; k++) begin
            w_col_ok[k] = {i_block_col, 2'(k)} < i_image_width;
            w_row_ok[k] = {i_block_row, 2'(k)} < i_image_height;
        end
        for (int k = 0; k < 16; k++) begin
            n_sums.mask[k] = w_col_ok[k % 4] && w_row_ok[k / 4];
        end
    end

    always_comb begin
        o_q_data = '0;
        for (int ch = 0; ch < 3; ch++) begin
            o_q_data.pal[0][ch] = r_sums.e0[ch];
            o_q_data.pal[1][ch] = r_sums.e1[ch];
            o_q_data.pal[2][ch] = r_sums.four ? dxt_pkg::div3(r_sums.s_a[ch]) : r_sums.half[ch];
            o_q_data.pal[3][ch] = r_sums.four ? dxt_pkg::div3(r_sums.s_b[ch]) : 8'd0;
        end
        o_q_data.ramp[0] = r_sums.a0;
        o_q_data.ramp[1] = r_sums.a1;
        for (int i = 2; i < 6; i++) begin
            o_q_data.ramp[i] = r_sums.a_gt ? dxt_pkg::div7(r_sums.asum[i-2])
                                           : dxt_pkg::div5(r_sums.asum[i-2]);
        end
        o_q_data.ramp[6] = r_sums.a_gt ? dxt_pkg::div7(r_sums.asum[4]) : 8'd0;
        o_q_data.ramp[7] = r_sums.a_gt ? dxt_pkg::div7(r_sums.asum[5]) : 8'd255;
        o_q_data.dxt5   = r_sums.dxt5;
        o_q_data.trans3 = !r_sums.four;
        o_q_data.cidx   = r_sums.cidx;
        o_q_data.aidx   = r_sums.aidx;
        o_q_data.bx     = r_sums.bx;
        o_q_data.by     = r_sums.by;
        o_q_data.mask   = r_sums.mask;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (w_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_sums <= n_sums;
        end
    end

endmodule

[hw/rtl/dxt_queue.sv]
module dxt_queue #(
    parameter int DEPTH = dxt_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr_valid,
    output logic          o_wr_ready,
    input  dxt_pkg::t_blk i_wr_data,
    output logic          o_rd_valid,
    input  logic          i_rd_ready,
    output dxt_pkg::t_blk o_rd_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    dxt_pkg::t_blk r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;
    logic w_push;
    logic w_pop;

    assign o_wr_ready = r_count != CNT_W'(DEPTH);
    assign o_rd_valid = r_count != '0;
    assign o_rd_data  = r_mem[r_rptr];
    assign w_push     = i_wr_valid && o_wr_ready;
    assign w_pop      = o_rd_valid && i_rd_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (w_pop) begin
                r_rptr <= (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_wr_data;
        end
    end

endmodule

[hw/rtl/dxt_back.sv]
`include "dxt_texture_block_decoder_macros.svh"

module dxt_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    output logic          o_q_ready,
    input  dxt_pkg::t_blk i_q_data,
    output logic          o_m_valid,
    input  logic          i_m_ready,
    output dxt_pkg::t_pix o_m_data
);

    logic           r_busy;
    dxt_pkg::t_blk  r_blk;
    logic           r_out_valid;
    dxt_pkg::t_pix  r_out;
    dxt_pkg::t_pix  n_out;
    logic           w_can_load;
    logic           w_emit;
    logic           w_last;
    logic           w_pop;
    logic [15:0]    w_iso;
    logic [3:0]     w_pos;
    logic [1:0]     w_ci;
    logic [2:0]     w_ai;
    logic [5:0]     w_abit;

    assign w_can_load = !r_out_valid || i_m_ready;
    assign w_emit     = w_can_load && r_busy;
    assign w_iso      = r_blk.mask & (~r_blk.mask + 16'd1);
    assign w_last     = (r_blk.mask & ~w_iso) == 16'd0;
    assign o_q_ready  = !r_busy || (w_emit && w_last);
    assign w_pop      = i_q_valid && o_q_ready;

    always_comb begin
        w_pos = '0;
        for (int k = 0; k < 16; k++) begin
            w_pos = w_pos | ({4{w_iso[k]}} & 4'(k));
        end
    end

    assign w_abit = {2'b0, w_pos} + {1'b0, w_pos, 1'b0};
    assign w_ci   = r_blk.cidx[{w_pos, 1'b0} +: 2];
    assign w_ai   = r_blk.aidx[w_abit +: 3];

    always_comb begin
        n_out.pixel_x    = {2'b0, r_blk.bx} * 16'd4 + {14'b0, w_pos[1:0]};
        n_out.pixel_y    = {2'b0, r_blk.by} * 16'd4 + {14'b0, w_pos[3:2]};
        n_out.red        = r_blk.pal[w_ci][dxt_pkg::CH_RED];
        n_out.green      = r_blk.pal[w_ci][dxt_pkg::CH_GREEN];
        n_out.blue       = r_blk.pal[w_ci][dxt_pkg::CH_BLUE];
        if (r_blk.dxt5) begin
            n_out.alpha = r_blk.ramp[w_ai];
        end else if (r_blk.trans3 && (w_ci == 2'd3)) begin
            n_out.alpha = 8'd0;
        end else begin
            n_out.alpha = 8'd255;
        end
        n_out.last_pixel = w_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_pop) begin
                r_busy <= 1'b1;
            end else if (w_emit && w_last) begin
                r_busy <= 1'b0;
            end
            if (w_can_load) begin
                r_out_valid <= w_emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_blk <= i_q_data;
        end else if (w_emit) begin
            r_blk.mask <= r_blk.mask & ~w_iso;
        end
        if (w_emit) begin
            r_out <= n_out;
        end
    end

    assign o_m_valid = r_out_valid;
    assign o_m_data  = r_out;

    `DXT_ASSERT_NOW(a_busy_has_pixels, i_clk, i_rst_n, r_busy, r_blk.mask != 16'd0,
        "busy with no pixels left")
    `DXT_ASSERT_NEXT(a_last_ends_block, i_clk, i_rst_n, w_emit && w_last && !w_pop, !r_busy,
        "block still busy after last pixel")
    `DXT_ASSERT_NEXT(a_one_pixel_per_emit, i_clk, i_rst_n, w_emit && !w_last,
        r_busy && ($countones(r_blk.mask) == $countones($past(r_blk.mask)) - 1),
        "pixel mask did not drop by one")
    `DXT_ASSERT_NEXT(a_emit_shows_valid, i_clk, i_rst_n, w_emit, r_out_valid,
        "emitted pixel not presented")

endmodule

[hw/rtl/dxt_texture_block_decoder.sv]
// DXT1 / DXT5 4x4 texture block decoder.
// Slave stream: one compressed block per transaction (colour half, alpha
// half, block column, block row). Master stream: one RGBA8888 pixel per
// transaction with its x and y, in row-major order inside the block;
// tlast marks the final pixel emitted for the block.
// Configuration: write decode mode, image width and image height through
// the write port while no block is in flight. Pixels at or beyond the
// image width or height are dropped; a block with no visible pixel emits
// nothing.
// Pipeline: the palette stage registers each block, the queue holds it, and
// the sequencer loads it into its block register and registers each pixel.
// Throughput: the pixel sequencer emits one pixel per cycle while the
// receiver is ready; the palette stage takes a block per cycle while the
// queue has room, and a two-entry queue lets it run ahead of the sequencer.
// Reset: configuration returns to mode DXT1 and a 1x1 image; the pipeline
// and queue empty. No clearing pass.
// Stall: while the receiver holds tready low the output pixel holds, the
// sequencer waits, and the queue fills before slave tready drops.
module dxt_texture_block_decoder #(
    parameter int QUEUE_DEPTH = dxt_pkg::QUEUE_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [dxt_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [dxt_pkg::CFG_DATA_W-1:0]  i_cfg_wr_data,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // color_part[63:0], alpha_part[127:64], block_col[141:128],
    // block_row[155:142], zero pad[159:156]
    input  logic [159:0]                    i_s_axis_tdata,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // pixel_x[15:0], pixel_y[31:16], red[39:32], green[47:40],
    // blue[55:48], alpha[63:56]
    output logic [63:0]                     o_m_axis_tdata,
    // last_pixel
    output logic                            o_m_axis_tlast
);

    logic          r_decode_mode;
    logic [15:0]   r_image_width;
    logic [15:0]   r_image_height;

    logic          w_fq_valid;
    logic          w_fq_ready;
    dxt_pkg::t_blk w_fq_data;
    logic          w_qb_valid;
    logic          w_qb_ready;
    dxt_pkg::t_blk w_qb_data;
    dxt_pkg::t_pix w_pix;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decode_mode  <= 1'b0;
            r_image_width  <= 16'd1;
            r_image_height <= 16'd1;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                dxt_pkg::REG_DECODE_MODE:  r_decode_mode  <= i_cfg_wr_data[0];
                dxt_pkg::REG_IMAGE_WIDTH:  r_image_width  <= i_cfg_wr_data;
                dxt_pkg::REG_IMAGE_HEIGHT: r_image_height <= i_cfg_wr_data;
                default: begin
                end
            endcase
        end
    end

    dxt_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_decode_mode  (r_decode_mode),
        .i_image_width  (r_image_width),
        .i_image_height (r_image_height),
        .i_s_valid      (i_s_axis_tvalid),
        .o_s_ready      (o_s_axis_tready),
        .i_color_part   (i_s_axis_tdata[63:0]),
        .i_alpha_part   (i_s_axis_tdata[127:64]),
        .i_block_col    (i_s_axis_tdata[141:128]),
        .i_block_row    (i_s_axis_tdata[155:142]),
        .o_q_valid      (w_fq_valid),
        .i_q_ready      (w_fq_ready),
        .o_q_data       (w_fq_data)
    );

    dxt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (w_fq_valid),
        .o_wr_ready (w_fq_ready),
        .i_wr_data  (w_fq_data),
        .o_rd_valid (w_qb_valid),
        .i_rd_ready (w_qb_ready),
        .o_rd_data  (w_qb_data)
    );

    dxt_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_qb_valid),
        .o_q_ready (w_qb_ready),
        .i_q_data  (w_qb_data),
        .o_m_valid (o_m_axis_tvalid),
        .i_m_ready (i_m_axis_tready),
        .o_m_data  (w_pix)
    );

    assign o_m_axis_tdata = {w_pix.alpha, w_pix.blue, w_pix.green, w_pix.red,
                             w_pix.pixel_y, w_pix.pixel_x};
    assign o_m_axis_tlast = w_pix.last_pixel;

endmodule
